FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: sv/ntlv_pkg.sv
`timescale 1ns / 1ps

package ntlv_pkg;

  typedef enum logic [12:0] {
    PH_TAG     = 13'b0000000000001,
    PH_LEN1    = 13'b0000000000010,
    PH_LENHI   = 13'b0000000000100,
    PH_LENLO   = 13'b0000000001000,
    PH_SKIP    = 13'b0000000010000,
    PH_HDR     = 13'b0000000100000,
    PH_TYPELEN = 13'b0000001000000,
    PH_PLEN    = 13'b0000010000000,
    PH_IDLEN   = 13'b0000100000000,
    PH_BODY    = 13'b0001000000000,
    PH_DEAD    = 13'b0010000000000,
    PH_AFTER   = 13'b0100000000000,
    PH_FAIL    = 13'b1000000000000
  } phase_t;

  localparam logic [2:0] ROLE_FRAME   = 3'd0;
  localparam logic [2:0] ROLE_HEADER  = 3'd1;
  localparam logic [2:0] ROLE_TYPE    = 3'd2;
  localparam logic [2:0] ROLE_ID      = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;
  localparam logic [2:0] ROLE_AFTER   = 3'd5;

  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_TERMINATOR = 4'd1;
  localparam logic [3:0] ST_NO_NDEF    = 4'd2;
  localparam logic [3:0] ST_TLV_TRUNC  = 4'd3;
  localparam logic [3:0] ST_BEYOND     = 4'd4;
  localparam logic [3:0] ST_MSG_TRUNC  = 4'd5;
  localparam logic [3:0] ST_TOO_SHORT  = 4'd6;
  localparam logic [3:0] ST_BAD_HDR    = 4'd7;
  localparam logic [3:0] ST_HDR_OVERRUN = 4'd8;
  localparam logic [3:0] ST_LEN_MISMATCH = 4'd9;

  localparam logic [7:0] TAG_NULL   = 8'h00;
  localparam logic [7:0] TAG_NDEF   = 8'h03;
  localparam logic [7:0] TAG_TERM   = 8'hFE;
  localparam logic [7:0] LEN_LONG   = 8'hFF;
  localparam logic [7:0] HDR_MB_ME  = 8'hC0;
  localparam logic [7:0] HDR_CF     = 8'h20;
  localparam logic [7:0] HDR_SR     = 8'h10;
  localparam logic [7:0] HDR_IL     = 8'h08;
  localparam logic [7:0] HDR_TNF    = 8'h07;

  localparam logic [15:0] USER_AREA_RESET = 16'd144;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic        done_res;
    logic [3:0]  status;
    logic [2:0]  record_tnf;
    logic [7:0]  type_length;
    logic [7:0]  id_length;
    logic [15:0] payload_length;
    logic [15:0] payload_offset;
  } result_t;

endpackage

FILE: sv/ntlv_parse_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntlv_parse_core import ntlv_pkg::*; #(
  parameter int POSITION_BITS = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        acc,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output result_t     res
);

  localparam int EB = ((POSITION_BITS > 16) ? POSITION_BITS : 16) + 1;
  localparam int SB = (EB > 33) ? EB : 33;

  logic [15:0]              user_area;
  phase_t                   phase, phase_next;
  logic [POSITION_BITS-1:0] position;
  logic                     tlv_is_ndef, tlv_is_ndef_next;
  logic [15:0]              length_acc, length_acc_next;
  logic [15:0]              skip_remaining, skip_remaining_next;
  logic [EB-1:0]            message_end, message_end_next;
  logic [7:0]               record_header, record_header_next;
  logic [7:0]               type_len_reg, type_len_reg_next;
  logic [7:0]               id_len_reg, id_len_reg_next;
  logic [31:0]              payload_len_reg, payload_len_reg_next;
  logic [1:0]               field_byte_count, field_byte_count_next;
  logic [3:0]               status_latch, status_latch_next;
  logic [EB-1:0]            payload_start, payload_start_next;

  logic [EB-1:0] pos_ext, pos1, rem, end_pos, pstart_cand;
  logic [15:0]   fin_len, skip_dec;
  logic [31:0]   plr_shift, plr_v;
  logic [7:0]    id_v;
  logic [SB-1:0] body_sum;
  logic          in_msg, do_finish, do_body;
  logic [2:0]    role;
  logic [3:0]    status;

  always_comb begin
    pos_ext     = EB'(position);
    pos1        = pos_ext + EB'(1);
    rem         = message_end - pos1;
    in_msg      = (phase == PH_HDR) || (phase == PH_TYPELEN) || (phase == PH_PLEN) ||
                  (phase == PH_IDLEN) || (phase == PH_BODY) || (phase == PH_DEAD);
    fin_len     = (phase == PH_LENLO) ? {length_acc[15:8], data_byte} : {8'h00, data_byte};
    end_pos     = pos1 + EB'(fin_len);
    skip_dec    = skip_remaining - 16'd1;
    plr_shift   = {payload_len_reg[23:0], data_byte};
    plr_v       = (phase == PH_PLEN) ? plr_shift : payload_len_reg;
    id_v        = (phase == PH_IDLEN) ? data_byte : id_len_reg;
    body_sum    = SB'(type_len_reg) + SB'(id_v) + SB'(plr_v);
    pstart_cand = pos1 + EB'(type_len_reg) + EB'(id_v);

    phase_next            = phase;
    tlv_is_ndef_next      = tlv_is_ndef;
    length_acc_next       = length_acc;
    skip_remaining_next   = skip_remaining;
    message_end_next      = message_end;
    record_header_next    = record_header;
    type_len_reg_next     = type_len_reg;
    id_len_reg_next       = id_len_reg;
    payload_len_reg_next  = payload_len_reg;
    field_byte_count_next = field_byte_count;
    status_latch_next     = status_latch;
    payload_start_next    = payload_start;
    role                  = ROLE_FRAME;
    do_finish             = 1'b0;
    do_body               = 1'b0;

    unique case (phase)
      PH_TAG: begin
        if (data_byte == TAG_TERM) begin
          status_latch_next = ST_TERMINATOR;
          phase_next        = PH_FAIL;
        end else if (data_byte != TAG_NULL) begin
          tlv_is_ndef_next = (data_byte == TAG_NDEF);
          phase_next       = PH_LEN1;
        end
      end
      PH_LEN1: begin
        if (data_byte == LEN_LONG) phase_next = PH_LENHI;
        else do_finish = 1'b1;
      end
      PH_LENHI: begin
        length_acc_next = {data_byte, 8'h00};
        phase_next      = PH_LENLO;
      end
      PH_LENLO: do_finish = 1'b1;
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 16'd0) phase_next = PH_TAG;
      end
      PH_HDR: begin
        role               = ROLE_HEADER;
        record_header_next = data_byte;
        if ((data_byte & HDR_MB_ME) != HDR_MB_ME || (data_byte & HDR_CF) != 8'h00) begin
          status_latch_next = ST_BAD_HDR;
          phase_next        = PH_DEAD;
        end else begin
          phase_next = PH_TYPELEN;
        end
      end
      PH_TYPELEN: begin
        role              = ROLE_HEADER;
        type_len_reg_next = data_byte;
        if ((record_header & HDR_SR) != 8'h00) begin
          if (rem == EB'(0)) begin
            status_latch_next = ST_HDR_OVERRUN;
            phase_next        = PH_DEAD;
          end else begin
            field_byte_count_next = 2'd0;
            phase_next            = PH_PLEN;
          end
        end else begin
          if (rem < EB'(4)) begin
            status_latch_next = ST_HDR_OVERRUN;
            phase_next        = PH_DEAD;
          end else begin
            field_byte_count_next = 2'd3;
            phase_next            = PH_PLEN;
          end
        end
      end
      PH_PLEN: begin
        role                 = ROLE_HEADER;
        payload_len_reg_next = plr_shift;
        if (field_byte_count != 2'd0) begin
          field_byte_count_next = field_byte_count - 2'd1;
        end else if ((record_header & HDR_IL) != 8'h00) begin
          if (rem == EB'(0)) begin
            status_latch_next = ST_HDR_OVERRUN;
            phase_next        = PH_DEAD;
          end else begin
            phase_next = PH_IDLEN;
          end
        end else begin
          do_body = 1'b1;
        end
      end
      PH_IDLEN: begin
        role            = ROLE_HEADER;
        id_len_reg_next = data_byte;
        do_body         = 1'b1;
      end
      PH_BODY: begin
        if (pos_ext >= payload_start) role = ROLE_PAYLOAD;
        else if (pos_ext >= payload_start - EB'(id_len_reg)) role = ROLE_ID;
        else role = ROLE_TYPE;
      end
      PH_AFTER: role = ROLE_AFTER;
      default: ;
    endcase

    if (do_finish) begin
      if (tlv_is_ndef) begin
        if (end_pos > EB'(user_area)) begin
          status_latch_next = ST_BEYOND;
          phase_next        = PH_FAIL;
        end else begin
          message_end_next = end_pos;
          length_acc_next  = fin_len;
          phase_next       = (fin_len == 16'd0) ? PH_AFTER : PH_HDR;
        end
      end else begin
        skip_remaining_next = fin_len;
        phase_next          = (fin_len == 16'd0) ? PH_TAG : PH_SKIP;
      end
    end

    if (do_body) begin
      if (SB'(rem) != body_sum) begin
        status_latch_next = ST_LEN_MISMATCH;
        phase_next        = PH_DEAD;
      end else begin
        payload_start_next = pstart_cand;
        phase_next         = PH_BODY;
      end
    end

    if (in_msg && rem == EB'(0) && phase_next != PH_FAIL) phase_next = PH_AFTER;

    unique case (phase_next) inside
      PH_FAIL: status = status_latch_next;
      PH_TAG: status = ST_NO_NDEF;
      PH_LEN1, PH_LENHI, PH_LENLO, PH_SKIP: status = ST_TLV_TRUNC;
      default: begin
        if (message_end_next > pos1) status = ST_MSG_TRUNC;
        else if (length_acc_next < 16'd3) status = ST_TOO_SHORT;
        else status = status_latch_next;
      end
    endcase

    res           = '0;
    res.byte_role = role;
    res.done_res  = last_byte;
    if (last_byte) begin
      res.status         = status;
      res.record_tnf     = record_header_next[2:0] & HDR_TNF[2:0];
      res.type_length    = type_len_reg_next;
      res.id_length      = id_len_reg_next;
      res.payload_length = (payload_len_reg_next[31:16] != 16'd0) ? 16'hFFFF
                                                                  : payload_len_reg_next[15:0];
      res.payload_offset = (payload_start_next[EB-1:16] != '0) ? 16'hFFFF
                                                               : payload_start_next[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      user_area <= USER_AREA_RESET;
    end else if (cfg_wen) begin
      user_area <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && last_byte)) begin
      phase            <= PH_TAG;
      position         <= '0;
      tlv_is_ndef      <= 1'b0;
      length_acc       <= '0;
      skip_remaining   <= '0;
      message_end      <= '0;
      record_header    <= '0;
      type_len_reg     <= '0;
      id_len_reg       <= '0;
      payload_len_reg  <= '0;
      field_byte_count <= '0;
      status_latch     <= ST_OK;
      payload_start    <= '0;
    end else if (acc) begin
      phase            <= phase_next;
      tlv_is_ndef      <= tlv_is_ndef_next;
      length_acc       <= length_acc_next;
      skip_remaining   <= skip_remaining_next;
      message_end      <= message_end_next;
      record_header    <= record_header_next;
      type_len_reg     <= type_len_reg_next;
      id_len_reg       <= id_len_reg_next;
      payload_len_reg  <= payload_len_reg_next;
      field_byte_count <= field_byte_count_next;
      status_latch     <= status_latch_next;
      payload_start    <= payload_start_next;
      if (position != '1) position <= position + POSITION_BITS'(1);
    end
  end

  `ASSERT_NEXT(a_clear_after_last, clk, rst, acc && last_byte,
               phase == PH_TAG && position == '0)
  `ASSERT_IMPLIES(a_pos_inside_msg, clk, rst, in_msg, message_end > EB'(position))
  `ASSERT_IMPLIES(a_payload_in_msg, clk, rst, phase == PH_BODY, payload_start <= message_end)

endmodule

FILE: sv/ntlv_out_skid.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ntlv_out_skid import ntlv_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_res,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    take;
  logic    acc;

  assign in_ready = ~skid_valid;
  assign take     = out_valid & out_ready;
  assign acc      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (acc) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid  <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if (out_valid && !take) skid_res <= in_res;
      else out_res <= in_res;
    end else if (take && skid_valid) begin
      out_res <= skid_res;
    end
  end

  `ASSERT_IMPLIES(a_skid_implies_out, clk, rst, skid_valid, out_valid)
  `ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !out_ready, skid_valid)
  `ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && out_ready, out_valid && !skid_valid)

endmodule

FILE: sv/ndef_tlv_record_parser.sv
`timescale 1ns / 1ps
// Parses a tag memory image, one byte per request at a sustained rate of one
// byte per clock while the master side keeps up: each byte goes through a
// single registered state update, and its result request is registered in
// the output register, or in one skid entry if that is held, so the slave
// side can take one more byte while the master side stalls; s_axis_tready
// drops only when both are full. Every byte yields its role in m_axis_tuser;
// the byte flagged by s_axis_tlast yields m_axis_tlast and the status and
// record fields in m_axis_tdata, and the parser then starts over afresh.
// Write user_area_bytes through cfg_wen/cfg_wdata only while the block is idle.

module ndef_tlv_record_parser import ntlv_pkg::*; #(
  parameter int POSITION_BITS = 17
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,      // user_area_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // status, record_tnf, type_length, id_length,
                                      // payload_length, payload_offset, zero pad
  output logic [2:0]  m_axis_tuser,   // byte_role
  output logic        m_axis_tlast    // done_res
);

  result_t core_res;
  result_t out_res;
  logic    acc;

  assign acc = s_axis_tvalid & s_axis_tready;

  ntlv_parse_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .acc       (acc),
    .data_byte (s_axis_tdata),
    .last_byte (s_axis_tlast),
    .res       (core_res)
  );

  ntlv_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_res    (core_res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tuser = out_res.byte_role;
  assign m_axis_tlast = out_res.done_res;
  assign m_axis_tdata = {1'b0, out_res.payload_offset, out_res.payload_length,
                         out_res.id_length, out_res.type_length,
                         out_res.record_tnf, out_res.status};

endmodule

FILE: dv/ndef_tlv_record_parser_test.sv
`timescale 1ns / 1ps

module ndef_tlv_record_parser_test;
  import ntlv_pkg::*;

  localparam int POS_BITS = 17;
  localparam longint unsigned POS_MAX = (64'd1 << POS_BITS) - 1;
  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_AT = 150;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  typedef enum {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_MOSTLY} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  ndef_tlv_record_parser #(.POSITION_BITS(POS_BITS)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  stream_byte_t pending_bytes[$];
  logic [7:0]   image_buf[$];
  result_t      expected_results[$];
  int           error_count = 0;
  int           results_seen = 0;
  int           cycle_count = 0;

  int          gap_left = 0;
  int          burst_left = 0;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;

  // parser shadow state
  logic [15:0]     user_area = USER_AREA_RESET;
  phase_t          ph = PH_TAG;
  longint unsigned cur_pos = 0;
  longint unsigned msg_end = 0;
  longint unsigned pay_start = 0;
  logic            tlv_ndef = 1'b0;
  logic [15:0]     len_acc = '0;
  logic [15:0]     skip_left = '0;
  logic [7:0]      hdr_q = '0;
  logic [7:0]      tl_q = '0;
  logic [7:0]      il_q = '0;
  logic [31:0]     pl_q = '0;
  logic [1:0]      fcount = '0;
  logic [3:0]      st_latch = ST_OK;

  logic [7:0] dir_bytes [25] = '{
    TAG_NDEF, 8'h03, 8'hD0, 8'h00, 8'h00,
    TAG_TERM,
    TAG_NULL,
    TAG_NDEF, LEN_LONG, 8'hFF, 8'hFF,
    TAG_NDEF, 8'h05, 8'hD1, 8'h01, 8'h01,
    TAG_NDEF, 8'h02, 8'hD0, 8'h00,
    TAG_NDEF, 8'h03, 8'h80, 8'h00, 8'h00
  };
  int dir_len [7] = '{5, 1, 1, 4, 5, 4, 5};

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic clear_parser();
    ph = PH_TAG;
    cur_pos = 0;
    msg_end = 0;
    pay_start = 0;
    tlv_ndef = 1'b0;
    len_acc = '0;
    skip_left = '0;
    hdr_q = '0;
    tl_q = '0;
    il_q = '0;
    pl_q = '0;
    fcount = '0;
    st_latch = ST_OK;
  endtask

  task automatic record_error(input logic [3:0] code);
    st_latch = code;
    ph = PH_DEAD;
  endtask

  task automatic take_length(input longint unsigned p, input logic [15:0] len);
    longint unsigned e;
    if (tlv_ndef) begin
      e = p + 1 + len;
      if (e > user_area) begin
        st_latch = ST_BEYOND;
        ph = PH_FAIL;
      end else begin
        msg_end = e;
        len_acc = len;
        ph = (len == 0) ? PH_AFTER : PH_HDR;
      end
    end else begin
      skip_left = len;
      ph = (len == 0) ? PH_TAG : PH_SKIP;
    end
  endtask

  task automatic check_lengths(input longint unsigned p);
    longint unsigned start;
    longint unsigned sum;
    start = p + 1;
    sum = 64'(tl_q) + 64'(il_q) + 64'(pl_q);
    if (msg_end - start != sum) begin
      record_error(ST_LEN_MISMATCH);
    end else begin
      pay_start = start + tl_q + il_q;
      ph = PH_BODY;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic lst);
    longint unsigned p;
    longint unsigned rem;
    logic [2:0]      role;
    logic [3:0]      st;
    logic            in_msg;
    result_t         r;
    p = cur_pos;
    role = ROLE_FRAME;
    rem = 0;
    in_msg = ph inside {PH_HDR, PH_TYPELEN, PH_PLEN, PH_IDLEN, PH_BODY, PH_DEAD};
    if (in_msg) rem = msg_end - (p + 1);
    case (ph)
      PH_TAG: begin
        if (b == TAG_TERM) begin
          st_latch = ST_TERMINATOR;
          ph = PH_FAIL;
        end else if (b != TAG_NULL) begin
          tlv_ndef = (b == TAG_NDEF);
          ph = PH_LEN1;
        end
      end
      PH_LEN1: begin
        if (b == LEN_LONG) ph = PH_LENHI;
        else take_length(p, {8'h00, b});
      end
      PH_LENHI: begin
        len_acc = {b, 8'h00};
        ph = PH_LENLO;
      end
      PH_LENLO: take_length(p, {len_acc[15:8], b});
      PH_SKIP: begin
        skip_left = skip_left - 1'b1;
        if (skip_left == 0) ph = PH_TAG;
      end
      PH_HDR: begin
        role = ROLE_HEADER;
        hdr_q = b;
        if ((b & HDR_MB_ME) != HDR_MB_ME || (b & HDR_CF) != 0) record_error(ST_BAD_HDR);
        else ph = PH_TYPELEN;
      end
      PH_TYPELEN: begin
        role = ROLE_HEADER;
        tl_q = b;
        if ((hdr_q & HDR_SR) != 0 ? rem < 1 : rem < 4) begin
          record_error(ST_HDR_OVERRUN);
        end else begin
          fcount = ((hdr_q & HDR_SR) != 0) ? 2'd0 : 2'd3;
          ph = PH_PLEN;
        end
      end
      PH_PLEN: begin
        role = ROLE_HEADER;
        pl_q = {pl_q[23:0], b};
        if (fcount != 0) begin
          fcount = fcount - 1'b1;
        end else if ((hdr_q & HDR_IL) != 0) begin
          if (rem < 1) record_error(ST_HDR_OVERRUN);
          else ph = PH_IDLEN;
        end else begin
          check_lengths(p);
        end
      end
      PH_IDLEN: begin
        role = ROLE_HEADER;
        il_q = b;
        check_lengths(p);
      end
      PH_BODY: begin
        if (p >= pay_start) role = ROLE_PAYLOAD;
        else if (p >= pay_start - il_q) role = ROLE_ID;
        else role = ROLE_TYPE;
      end
      PH_AFTER: role = ROLE_AFTER;
      default: ;
    endcase

    if (in_msg && rem == 0 && ph != PH_FAIL) ph = PH_AFTER;

    r = '0;
    r.byte_role = role;
    if (lst) begin
      case (ph)
        PH_FAIL: st = st_latch;
        PH_TAG: st = ST_NO_NDEF;
        PH_LEN1, PH_LENHI, PH_LENLO, PH_SKIP: st = ST_TLV_TRUNC;
        default: begin
          if (msg_end > p + 1) st = ST_MSG_TRUNC;
          else if (len_acc < 3) st = ST_TOO_SHORT;
          else st = st_latch;
        end
      endcase
      r.done_res = 1'b1;
      r.status = st;
      r.record_tnf = hdr_q[2:0];
      r.type_length = tl_q;
      r.id_length = il_q;
      r.payload_length = (pl_q > 32'hFFFF) ? 16'hFFFF : pl_q[15:0];
      r.payload_offset = (pay_start > 64'hFFFF) ? 16'hFFFF : pay_start[15:0];
      clear_parser();
    end else if (cur_pos < POS_MAX) begin
      cur_pos++;
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch on result %0d: %s", $time, results_seen, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got !== want) report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // sender: one request per accepted byte, offered in bursts
  always @(posedge clk) begin
    stream_byte_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= nxt.data;
          s_axis_tlast <= nxt.last;
          if (burst_left != 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern is redrawn at random, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end else begin
        mode_left--;
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        case (ready_mode)
          READY_ALWAYS: m_axis_tready <= 1'b1;
          READY_HALF:   m_axis_tready <= 1'($urandom_range(0, 1));
          READY_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default:      m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_results.pop_front();
        check_field("byte_role", m_axis_tuser, want.byte_role);
        check_field("done_res", m_axis_tlast, want.done_res);
        check_field("status", m_axis_tdata[3:0], want.status);
        check_field("record_tnf", m_axis_tdata[6:4], want.record_tnf);
        check_field("type_length", m_axis_tdata[14:7], want.type_length);
        check_field("id_length", m_axis_tdata[22:15], want.id_length);
        check_field("payload_length", m_axis_tdata[38:23], want.payload_length);
        check_field("payload_offset", m_axis_tdata[54:39], want.payload_offset);
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_image_byte(input logic [7:0] b);
    image_buf.insert(image_buf.size(), b);
  endtask

  task automatic flush_image();
    stream_byte_t sb;
    foreach (image_buf[i]) begin
      sb.data = image_buf[i];
      sb.last = (i == image_buf.size() - 1);
      pending_bytes.insert(pending_bytes.size(), sb);
    end
    image_buf.delete();
  endtask

  task automatic add_other_tlv();
    logic [7:0] tag;
    int         n;
    do tag = 8'($urandom_range(1, 255)); while (tag == TAG_NDEF || tag == TAG_TERM);
    add_image_byte(tag);
    if ($urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 6);
      add_image_byte(LEN_LONG);
      add_image_byte(8'(n >> 8));
      add_image_byte(8'(n));
    end else begin
      n = $urandom_range(0, 6);
      add_image_byte(8'(n));
    end
    repeat (n) add_image_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic add_ndef_message(input bit big);
    logic [7:0] hdr;
    logic [7:0] rec[$];
    int         tl, idl, pl, n;
    bit         sr, il;
    sr = !big && $urandom_range(0, 2) != 0;
    il = $urandom_range(0, 2) == 0;
    tl = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
    idl = il ? $urandom_range(0, 3) : 0;
    if (big) pl = $urandom_range(200, 700);
    else pl = sr ? $urandom_range(0, 12) : $urandom_range(0, 24);
    hdr = HDR_MB_ME | 8'($urandom_range(0, 7));
    if (sr) hdr = hdr | HDR_SR;
    if (il) hdr = hdr | HDR_IL;
    rec.insert(rec.size(), hdr);
    rec.insert(rec.size(), 8'(tl));
    if (!sr) begin
      rec.insert(rec.size(), 8'h00);
      rec.insert(rec.size(), 8'h00);
      rec.insert(rec.size(), 8'(pl >> 8));
    end
    rec.insert(rec.size(), 8'(pl));
    if (il) rec.insert(rec.size(), 8'(idl));
    repeat (tl + idl + pl) rec.insert(rec.size(), 8'($urandom_range(0, 255)));
    n = rec.size();
    add_image_byte(TAG_NDEF);
    if (n < 255 && $urandom_range(0, 3) != 0) begin
      add_image_byte(8'(n));
    end else begin
      add_image_byte(LEN_LONG);
      add_image_byte(8'(n >> 8));
      add_image_byte(8'(n));
    end
    foreach (rec[i]) add_image_byte(rec[i]);
  endtask

  task automatic random_images(input int target, input bit allow_big);
    int sent, kind, n, idx;
    sent = 0;
    while (sent < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 7) begin
        repeat ($urandom_range(0, 2)) begin
          if ($urandom_range(0, 1) == 0) add_image_byte(TAG_NULL);
          else add_other_tlv();
        end
        add_ndef_message(allow_big && $urandom_range(0, 24) == 0);
        case ($urandom_range(0, 3))
          0: ;
          1: add_image_byte(TAG_TERM);
          2: repeat ($urandom_range(1, 3)) add_image_byte(8'($urandom_range(0, 255)));
          default: add_other_tlv();
        endcase
        // broken variants: corrupt a bit, or cut the image short
        if (kind >= 6) begin
          case ($urandom_range(0, 2))
            0: begin
              idx = $urandom_range(0, image_buf.size() - 1);
              image_buf[idx] = image_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            1: begin
              n = $urandom_range(1, image_buf.size());
              while (image_buf.size() > n) void'(image_buf.pop_back());
            end
            default: begin
              idx = $urandom_range(0, (image_buf.size() < 12 ? image_buf.size() : 12) - 1);
              image_buf[idx] = image_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
          endcase
        end
      end else if (kind == 8) begin
        add_image_byte(TAG_NDEF);
        n = $urandom_range(0, 4);
        add_image_byte(8'(n));
        repeat (n) add_image_byte(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0) void'(image_buf.pop_back());
      end else begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 3) == 0) add_image_byte(TAG_NDEF);
          else add_image_byte(8'($urandom_range(0, 255)));
        end
      end
      sent += image_buf.size();
      flush_image();
    end
  endtask

  task automatic drain();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_user_area(input logic [15:0] v);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    user_area = v;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    int idx;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    idx = 0;
    foreach (dir_len[i]) begin
      repeat (dir_len[i]) begin
        add_image_byte(dir_bytes[idx]);
        idx++;
      end
      flush_image();
    end
    drain();
    set_user_area(16'hFFFF);
    random_images(250, 1'b1);
    drain();
    set_user_area(16'd1);
    random_images(60, 1'b0);
    drain();
    set_user_area(16'd0);
    random_images(40, 1'b0);
    drain();
    set_user_area(16'($urandom_range(16, 200)));
    random_images(250, 1'b0);
    drain();
    set_user_area(USER_AREA_RESET);
    random_images(250, 1'b0);
    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/ntlv_pkg.sv
sv/ntlv_parse_core.sv
sv/ntlv_out_skid.sv
sv/ndef_tlv_record_parser.sv
dv/ndef_tlv_record_parser_test.sv
